@@ rtl/abkf_pkg.sv @@
// Package with the sequencer states, widths and saturation helper of the angle/bias filter.
package abkf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned StepW  = 16;
  localparam int unsigned MulAW  = 35;
  localparam int unsigned MulBW  = 33;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned WideW  = 72;
  localparam int unsigned NumW   = 56;
  localparam int unsigned DenW   = 34;
  localparam int unsigned QuoW   = NumW + 1;

  localparam logic [1:0] CFG_QA = 2'd0;
  localparam logic [1:0] CFG_QB = 2'd1;
  localparam logic [1:0] CFG_R  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RATE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_S,
    ST_D0, ST_D1, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_OUT
  } state_t;

  typedef struct packed {
    logic           start;
    logic signed [NumW-1:0] num;
    logic signed [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic signed [QuoW-1:0] quo;
  } div_rsp_t;

  // Saturate to 32 bits signed; bit 32 of the result flags saturation.
  function automatic logic [32:0] sat32(input logic signed [WideW-1:0] x);
    logic [32:0] r;
    if (x > 72'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (x < -72'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/abkf_mul.sv @@
// Shared signed multiplier with a registered product.
module abkf_mul (
  input  logic                            clk,
  input  logic signed [abkf_pkg::MulAW-1:0] a,
  input  logic signed [abkf_pkg::MulBW-1:0] b,
  output logic signed [abkf_pkg::ProdW-1:0] prod
);
  import abkf_pkg::*;

  logic signed [ProdW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= ProdW'(a) * ProdW'(b);
  end

  assign prod = prod_r;
endmodule

@@ rtl/abkf_div.sv @@
// Serial restoring signed divider, one quotient bit per cycle, truncating toward zero.
module abkf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  abkf_pkg::div_req_t  req,
  output abkf_pkg::div_rsp_t  rsp
);
  import abkf_pkg::*;

  logic [NumW-1:0]   num_r, num_nxt;
  logic [DenW-1:0]   den_r, den_nxt;
  logic [DenW-1:0]   rem_r, rem_nxt;
  logic [NumW-1:0]   quo_r, quo_nxt;
  logic              neg_r, neg_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DenW:0]     rem_sh;
  logic [DenW:0]     diff;

  assign rem_sh = {rem_r, num_r[NumW-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt = req.num[NumW-1] ? NumW'(-req.num) : NumW'(req.num);
      den_nxt = req.den[DenW-1] ? DenW'(-req.den) : DenW'(req.den);
      neg_nxt = req.num[NumW-1] ^ req.den[DenW-1];
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = 6'(NumW);
    end else if (cnt_r != '0) begin
      num_nxt = {num_r[NumW-2:0], 1'b0};
      if (!diff[DenW]) begin
        rem_nxt = diff[DenW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DenW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
endmodule

@@ rtl/angle_bias_kalman_filter_top.sv @@
// Top level of the two-state angle/bias filter: sequencer, state registers and stream ports.
// A new input beat is accepted only in the idle step, once the current beat is through the sequencer.
// The two passes of the serial divider dominate the time per beat.
// A zero innovation covariance skips the divider.
// A stalled result beat holds the sequencer in its output step until it is taken.
// Synchronous active-low reset clears the filter state, covariance and handshakes
// and loads the default noise registers.
module angle_bias_kalman_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // measured_angle [31:0], measured_rate [63:32], time_step [79:64]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // angle_estimate [31:0], rate_estimate [63:32], bias_estimate [95:64]
  output logic [95:0] out_tdata,
  // saturated [0]
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);
  import abkf_pkg::*;

  state_t state_r, state_nxt;

  logic [CfgW-1:0] qa_r, qb_r, rn_r;
  logic signed [31:0] ma_r, mr_r;
  logic [StepW-1:0] d_r;
  logic signed [31:0] angle_r, bias_r, rate_r;
  logic signed [31:0] cov0_r, cov1_r, cov2_r, cov3_r;
  logic signed [31:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic signed [31:0] y_r, k0_r, k1_r;
  logic signed [DenW-1:0] s_r;
  logic signed [MulAW-1:0] inner_r;
  logic flag_r;
  logic out_valid_r;
  logic [95:0] out_data_r;
  logic out_user_r;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] r16, r24;
  logic signed [WideW-1:0] sat_a_in, sat_b_in;
  logic [32:0] sat_a, sat_b;
  logic signed [DenW-1:0] s_c;
  logic signed [MulBW-1:0] d_ext;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign d_ext = MulBW'($signed({1'b0, d_r}));
  assign r16   = (prod + ProdW'(68'sd32768)) >>> 16;
  assign r24   = (prod + ProdW'(68'sd8388608)) >>> 24;
  assign s_c   = DenW'(pp00_r) + DenW'($signed({1'b0, rn_r}));
  assign sat_a = sat32(sat_a_in);
  assign sat_b = sat32(sat_b_in);

  abkf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  abkf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_RATE;
      ST_RATE: state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_S;
      ST_S:    state_nxt = (s_c == '0) ? ST_C1 : ST_D0;
      ST_D0:   if (div_rsp.done) state_nxt = ST_D1;
      ST_D1:   if (div_rsp.done) state_nxt = ST_C1;
      ST_C1:   state_nxt = ST_C2;
      ST_C2:   state_nxt = ST_C3;
      ST_C3:   state_nxt = ST_C4;
      ST_C4:   state_nxt = ST_C5;
      ST_C5:   state_nxt = ST_C6;
      ST_C6:   state_nxt = ST_C7;
      ST_C7:   state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    sat_a_in    = '0;
    sat_b_in    = '0;
    div_req     = '0;
    case (state_r)
      ST_RATE: sat_a_in = WideW'(mr_r) - WideW'(bias_r);
      ST_M1: begin
        mul_a = MulAW'(rate_r);
        mul_b = d_ext;
      end
      ST_M2: begin
        sat_a_in = WideW'(angle_r) + WideW'(r16);
        mul_a    = MulAW'(cov3_r);
        mul_b    = d_ext;
      end
      ST_M3: begin
        sat_a_in = WideW'(cov1_r) - WideW'(r16);
        sat_b_in = WideW'(cov2_r) - WideW'(r16);
        mul_a    = MulAW'($signed({1'b0, qb_r}));
        mul_b    = d_ext;
      end
      ST_M4: begin
        sat_a_in = WideW'(cov3_r) + WideW'(r16);
        mul_a    = inner_r;
        mul_b    = d_ext;
      end
      ST_M5: begin
        sat_a_in = WideW'(cov0_r) + WideW'(r16);
        sat_b_in = WideW'(ma_r) - WideW'(angle_r);
      end
      ST_S: begin
        div_req.start = (s_c != '0);
        div_req.num   = {pp00_r, 24'd0};
        div_req.den   = s_c;
      end
      ST_D0: begin
        sat_a_in      = WideW'(div_rsp.quo);
        div_req.start = div_rsp.done;
        div_req.num   = {pp10_r, 24'd0};
        div_req.den   = s_r;
      end
      ST_D1: sat_a_in = WideW'(div_rsp.quo);
      ST_C1: begin
        mul_a = MulAW'(k0_r);
        mul_b = MulBW'(y_r);
      end
      ST_C2: begin
        sat_a_in = WideW'(angle_r) + WideW'(r24);
        mul_a    = MulAW'(k1_r);
        mul_b    = MulBW'(y_r);
      end
      ST_C3: begin
        sat_a_in = WideW'(bias_r) + WideW'(r24);
        mul_a    = MulAW'(k0_r);
        mul_b    = MulBW'(pp00_r);
      end
      ST_C4: begin
        sat_a_in = WideW'(pp00_r) - WideW'(r24);
        mul_a    = MulAW'(k0_r);
        mul_b    = MulBW'(pp01_r);
      end
      ST_C5: begin
        sat_a_in = WideW'(pp01_r) - WideW'(r24);
        mul_a    = MulAW'(k1_r);
        mul_b    = MulBW'(pp00_r);
      end
      ST_C6: begin
        sat_a_in = WideW'(pp10_r) - WideW'(r24);
        mul_a    = MulAW'(k1_r);
        mul_b    = MulBW'(pp01_r);
      end
      ST_C7: sat_a_in = WideW'(pp11_r) - WideW'(r24);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qa_r        <= 31'd16777;
      qb_r        <= 31'd50332;
      rn_r        <= 31'd503316;
      angle_r     <= '0;
      bias_r      <= '0;
      rate_r      <= '0;
      cov0_r      <= '0;
      cov1_r      <= '0;
      cov2_r      <= '0;
      cov3_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_QA:  qa_r <= cfg_wdata;
          CFG_QB:  qb_r <= cfg_wdata;
          CFG_R:   rn_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && (state_r != ST_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid) flag_r <= 1'b0;
        ST_RATE: begin
          rate_r <= sat_a[31:0];
          flag_r <= flag_r | sat_a[32];
        end
        ST_M2: begin
          angle_r <= sat_a[31:0];
          flag_r  <= flag_r | sat_a[32];
        end
        ST_M3: flag_r <= flag_r | sat_a[32] | sat_b[32];
        ST_M4: flag_r <= flag_r | sat_a[32];
        ST_M5: flag_r <= flag_r | sat_a[32] | sat_b[32];
        ST_S:  if (s_c == '0) flag_r <= 1'b1;
        ST_D0: if (div_rsp.done) flag_r <= flag_r | sat_a[32];
        ST_D1: if (div_rsp.done) flag_r <= flag_r | sat_a[32];
        ST_C2: begin
          angle_r <= sat_a[31:0];
          flag_r  <= flag_r | sat_a[32];
        end
        ST_C3: begin
          bias_r <= sat_a[31:0];
          flag_r <= flag_r | sat_a[32];
        end
        ST_C4: begin
          cov0_r <= sat_a[31:0];
          flag_r <= flag_r | sat_a[32];
        end
        ST_C5: begin
          cov1_r <= sat_a[31:0];
          flag_r <= flag_r | sat_a[32];
        end
        ST_C6: begin
          cov2_r <= sat_a[31:0];
          flag_r <= flag_r | sat_a[32];
        end
        ST_C7: begin
          cov3_r <= sat_a[31:0];
          flag_r <= flag_r | sat_a[32];
        end
        ST_OUT: if (!out_valid_r || out_tready) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ma_r <= in_tdata[31:0];
        mr_r <= in_tdata[63:32];
        d_r  <= in_tdata[79:64];
      end
      ST_M3: begin
        pp01_r  <= sat_a[31:0];
        pp10_r  <= sat_b[31:0];
        inner_r <= MulAW'(r16) - MulAW'(cov1_r) - MulAW'(cov2_r)
                   + MulAW'($signed({1'b0, qa_r}));
      end
      ST_M4: pp11_r <= sat_a[31:0];
      ST_M5: begin
        pp00_r <= sat_a[31:0];
        y_r    <= sat_b[31:0];
      end
      ST_S: begin
        s_r  <= s_c;
        k0_r <= '0;
        k1_r <= '0;
      end
      ST_D0: if (div_rsp.done) k0_r <= sat_a[31:0];
      ST_D1: if (div_rsp.done) k1_r <= sat_a[31:0];
      ST_OUT: if (!out_valid_r || out_tready) begin
        out_data_r <= {bias_r, rate_r, angle_r};
        out_user_r <= flag_r;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule

@@ rtl/abkf_checker.sv @@
// Port-level checker for the filter top level, attached by bind.
module abkf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a beat is still in work");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
endmodule

bind angle_bias_kalman_filter_top abkf_checker u_abkf_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready)
);
